>>> hw/rtl/sfd_pkg.sv
// Shared types and constants for the sonar frame deframer.
// No dependencies; every other file of the block refers to it by scoped name.
package sfd_pkg;

    // Frame sync bytes
    localparam logic [7:0] SYNC_B = 8'h42;  // 'B'
    localparam logic [7:0] SYNC_R = 8'h52;  // 'R'

    // Default hard ceiling on payload length
    localparam int PAYLOAD_LIMIT_DEF = 4096;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 12;
    localparam int HALF_W   = 16;
    localparam int MAXPL_W  = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXP_DEST    = 2'd1;

    // Register reset values
    localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_RST = 13'd1024;
    localparam logic [BYTE_W-1:0]  EXP_DEST_RST    = 8'd0;

    typedef enum logic [3:0] {
        PH_HUNT_B  = 4'd0,
        PH_HUNT_R  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_LEN_HI  = 4'd3,
        PH_ID_LO   = 4'd4,
        PH_ID_HI   = 4'd5,
        PH_SRC     = 4'd6,
        PH_DST     = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_CK_LO   = 4'd9,
        PH_CK_HI   = 4'd10
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD_SUM = 2'd2,
        KIND_DROP    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   data_byte;
        logic [INDEX_W-1:0]  byte_index;
        logic [HALF_W-1:0]   frame_pid;
        logic [HALF_W-1:0]   body_len;
        logic [BYTE_W-1:0]   src_node;
        logic                frame_end;
    } t_result;

endpackage

>>> hw/rtl/sfd_if.sv
// Valid/ready channel interfaces for the sonar frame deframer:
// received bytes, results and configuration writes. Depends on sfd_pkg.
interface sfd_byte_if;
    logic                       valid;
    logic                       ready;
    logic [sfd_pkg::BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface sfd_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [sfd_pkg::BYTE_W-1:0]  data_byte;
    logic [sfd_pkg::INDEX_W-1:0] byte_index;
    logic [sfd_pkg::HALF_W-1:0]  frame_pid;
    logic [sfd_pkg::HALF_W-1:0]  body_len;
    logic [sfd_pkg::BYTE_W-1:0]  src_node;
    logic                        frame_end;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output frame_pid, output body_len, output src_node,
                    output frame_end, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input frame_pid, input body_len, input src_node,
                    input frame_end, output ready);
endinterface

interface sfd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sfd_pkg::CFG_ADDR_W-1:0] index;
    logic [sfd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/sfd_core.sv
// Deframing state machine: header capture, checksum accumulation, result build.
// Depends on sfd_pkg.
module sfd_core #(
    parameter int PAYLOAD_LIMIT = sfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [sfd_pkg::BYTE_W-1:0]         i_byte,
    input  logic [sfd_pkg::MAXPL_W-1:0]        i_max_payload,
    input  logic [sfd_pkg::BYTE_W-1:0]         i_exp_dest,
    output logic                               o_res_valid,
    output sfd_pkg::t_result                   o_res
);
    localparam int CNT_W = $clog2(PAYLOAD_LIMIT + 1);
    localparam logic [16:0] LIMIT_C = 17'(PAYLOAD_LIMIT);

    sfd_pkg::t_phase               r_phase, n_phase;
    logic [sfd_pkg::HALF_W-1:0]    r_len, n_len;
    logic [sfd_pkg::HALF_W-1:0]    r_id, n_id;
    logic [sfd_pkg::BYTE_W-1:0]    r_src, n_src;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [sfd_pkg::HALF_W-1:0]    r_sum, n_sum;
    logic [sfd_pkg::BYTE_W-1:0]    r_ck_lo, n_ck_lo;

    logic [sfd_pkg::HALF_W-1:0]    sum_add;
    logic [16:0]                   limit;
    logic [CNT_W-1:0]              cnt_inc;
    logic [sfd_pkg::HALF_W-1:0]    cnt_ext;

    assign sum_add = r_sum + {8'd0, i_byte};
    assign limit   = (17'(i_max_payload) < LIMIT_C) ? 17'(i_max_payload) : LIMIT_C;
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign cnt_ext = 16'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfd_pkg::PH_HUNT_B;
            r_len   <= '0;
            r_id    <= '0;
            r_src   <= '0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_ck_lo <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_id    <= n_id;
            r_src   <= n_src;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_ck_lo <= n_ck_lo;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_id    = r_id;
        n_src   = r_src;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_ck_lo = r_ck_lo;

        o_res_valid          = 1'b0;
        o_res.kind           = sfd_pkg::KIND_DATA;
        o_res.data_byte      = '0;
        o_res.byte_index     = '0;
        o_res.frame_pid      = r_id;
        o_res.body_len       = r_len;
        o_res.src_node       = r_src;
        o_res.frame_end      = 1'b0;

        case (r_phase)
            sfd_pkg::PH_HUNT_R: begin
                if (i_byte == sfd_pkg::SYNC_R) begin
                    n_sum   = 16'({8'd0, sfd_pkg::SYNC_B} + {8'd0, sfd_pkg::SYNC_R});
                    n_phase = sfd_pkg::PH_LEN_LO;
                end else if (i_byte != sfd_pkg::SYNC_B) begin
                    n_phase = sfd_pkg::PH_HUNT_B;
                end
            end
            sfd_pkg::PH_LEN_LO: begin
                n_len   = {8'd0, i_byte};
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_LEN_HI;
            end
            sfd_pkg::PH_LEN_HI: begin
                n_len   = {i_byte, r_len[7:0]};
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_ID_LO;
            end
            sfd_pkg::PH_ID_LO: begin
                n_id    = {8'd0, i_byte};
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_ID_HI;
            end
            sfd_pkg::PH_ID_HI: begin
                n_id    = {i_byte, r_id[7:0]};
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_SRC;
            end
            sfd_pkg::PH_SRC: begin
                n_src   = i_byte;
                n_sum   = sum_add;
                n_phase = sfd_pkg::PH_DST;
            end
            sfd_pkg::PH_DST: begin
                n_sum = sum_add;
                if (i_byte != i_exp_dest || {1'b0, r_len} > limit) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = sfd_pkg::KIND_DROP;
                    o_res.frame_end = 1'b1;
                    n_phase         = sfd_pkg::PH_HUNT_B;
                end else begin
                    n_cnt   = '0;
                    n_phase = (r_len == '0) ? sfd_pkg::PH_CK_LO : sfd_pkg::PH_PAYLOAD;
                end
            end
            sfd_pkg::PH_PAYLOAD: begin
                n_sum            = sum_add;
                o_res_valid      = 1'b1;
                o_res.data_byte  = i_byte;
                o_res.byte_index = cnt_ext[sfd_pkg::INDEX_W-1:0];
                n_cnt            = cnt_inc;
                if (16'(cnt_inc) >= r_len) begin
                    n_phase = sfd_pkg::PH_CK_LO;
                end
            end
            sfd_pkg::PH_CK_LO: begin
                n_ck_lo = i_byte;
                n_phase = sfd_pkg::PH_CK_HI;
            end
            sfd_pkg::PH_CK_HI: begin
                o_res_valid     = 1'b1;
                o_res.frame_end = 1'b1;
                o_res.kind      = ({i_byte, r_ck_lo} == r_sum) ? sfd_pkg::KIND_GOOD
                                                               : sfd_pkg::KIND_BAD_SUM;
                n_phase         = sfd_pkg::PH_HUNT_B;
            end
            default: begin
                n_phase = (i_byte == sfd_pkg::SYNC_B) ? sfd_pkg::PH_HUNT_R
                                                      : sfd_pkg::PH_HUNT_B;
            end
        endcase

        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end
endmodule

>>> hw/rtl/sfd_skid.sv
// Result register with one skid entry, so bytes keep flowing while a result waits.
// Depends on sfd_pkg.
module sfd_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sfd_pkg::t_result i_data,
    output logic             o_in_ready,
    output logic             o_valid,
    output sfd_pkg::t_result o_data,
    input  logic             i_out_ready
);
    logic             r_out_v, n_out_v;
    logic             r_skid_v, n_skid_v;
    sfd_pkg::t_result r_out, n_out;
    sfd_pkg::t_result r_skid, n_skid;
    logic             take;

    assign take       = r_out_v & i_out_ready;
    assign o_in_ready = ~r_skid_v;
    assign o_valid    = r_out_v;
    assign o_data     = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (i_valid) begin
            if (!r_out_v || take) begin
                n_out   = i_data;
                n_out_v = 1'b1;
            end else begin
                n_skid   = i_data;
                n_skid_v = 1'b1;
            end
        end else if (take) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end
endmodule

>>> hw/rtl/sonar_frame_deframer.sv
// Top level of the sonar frame deframer: config registers, core and result buffer.
// Depends on sfd_pkg, sfd_if, sfd_core and sfd_skid.
//
// Usage:
//   i_byte carries one received byte per word. Frames are 'B' 'R', length (LE16),
//   packet id (LE16), source, destination, payload, checksum (LE16, byte sum).
//   o_res gives one word per payload byte (kind 0) and one closing word per frame:
//   kind 1 good, 2 checksum bad, 3 header dropped (wrong destination or too long).
//   Bytes between frames, header bytes and the low checksum byte give no word.
//   i_cfg writes max_payload (index 0) and expected_destination (index 1); it is
//   always ready and should be written only while the block is idle.
// Timing:
//   A byte is accepted while i_byte.ready is high; its result word is registered in
//   the output register, or the skid entry if that is full. The state update (one 16-bit
//   add and one length compare) sustains one byte per cycle while results are taken.
// Stall:
//   One skid entry sits behind the output register, so a byte is still taken
//   while a result waits; i_byte.ready drops only when both are full.
// Reset:
//   i_rst_n (synchronous) returns to hunting for 'B', empties the output
//   stages and restores max_payload = 1024, expected_destination = 0.
module sonar_frame_deframer #(
    parameter int PAYLOAD_LIMIT = sfd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfd_byte_if.sink  i_byte,
    sfd_cfg_if.sink   i_cfg,
    sfd_res_if.source o_res
);
    logic [sfd_pkg::MAXPL_W-1:0] r_max_payload;
    logic [sfd_pkg::BYTE_W-1:0]  r_exp_dest;

    logic             in_ready;
    logic             accept;
    logic             core_valid;
    sfd_pkg::t_result core_res;
    sfd_pkg::t_result out_res;

    // Config port: always ready, unknown indexes are ignored
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= sfd_pkg::MAX_PAYLOAD_RST;
            r_exp_dest    <= sfd_pkg::EXP_DEST_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                sfd_pkg::REG_MAX_PAYLOAD: r_max_payload <= i_cfg.data;
                sfd_pkg::REG_EXP_DEST:    r_exp_dest    <= i_cfg.data[sfd_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_byte.ready = in_ready;
    assign accept       = i_byte.valid & in_ready;

    sfd_core #(
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (i_byte.byte_in),
        .i_max_payload (r_max_payload),
        .i_exp_dest    (r_exp_dest),
        .o_res_valid   (core_valid),
        .o_res         (core_res)
    );

    sfd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (core_valid),
        .i_data      (core_res),
        .o_in_ready  (in_ready),
        .o_valid     (o_res.valid),
        .o_data      (out_res),
        .i_out_ready (o_res.ready)
    );

    assign o_res.kind           = out_res.kind;
    assign o_res.data_byte      = out_res.data_byte;
    assign o_res.byte_index     = out_res.byte_index;
    assign o_res.frame_pid      = out_res.frame_pid;
    assign o_res.body_len       = out_res.body_len;
    assign o_res.src_node       = out_res.src_node;
    assign o_res.frame_end      = out_res.frame_end;

`ifndef SYNTHESIS
    // Core only produces a word for an accepted byte
    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_valid |-> accept)
        else $error("result produced without an accepted byte");

    // Input stalls only when the output register is holding a word
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> o_res.valid)
        else $error("input stalled with empty output");

    // Frame closing words and payload words are exclusive
    a_end_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.frame_end == (o_res.kind != sfd_pkg::KIND_DATA)))
        else $error("frame_end disagrees with kind");

    // A stalled output keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(out_res)))
        else $error("output word changed while stalled");
`endif
endmodule

>>> test/tb_sonar_frame_deframer.sv
`timescale 1ns / 1ps
// Testbench for sonar_frame_deframer: random and directed byte streams of framed messages,
// checked word by word against an in-bench deframer predictor.
// Depends on sfd_pkg, sfd_if and the deframer RTL.
module tb_sonar_frame_deframer;

    localparam int IDLE_PCT      = 34;    // chance in a hundred that a side idles
    localparam int WATCHDOG_MAX  = 2000;  // cycles without any accepted word
    localparam int SETTLE_CYCLES = 8;     // output register plus skid entry, with margin
    localparam int PAYLOAD_CEIL  = sfd_pkg::PAYLOAD_LIMIT_DEF;

    // Indexes with no register behind them; writes there must change nothing
    localparam logic [sfd_pkg::CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [sfd_pkg::CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #2 i_clk = ~i_clk;

    sfd_byte_if byte_ch ();
    sfd_cfg_if  cfg_ch ();
    sfd_res_if  res_ch ();

    sonar_frame_deframer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Stimulus side
    logic [7:0] rx_bytes_q[$];   // bytes waiting for the driver
    int         frame_bytes = 0; // bytes pushed as part of frames (noise excluded)
    bit         byte_taken  = 1'b0;
    bit         steady      = 1'b0; // suppresses idling on both sides

    // Predictor copy of the registers
    logic [sfd_pkg::MAXPL_W-1:0] cfg_max_payload = sfd_pkg::MAX_PAYLOAD_RST;
    logic [7:0]                  cfg_dest        = sfd_pkg::EXP_DEST_RST;

    // Predictor copy of the deframer state
    sfd_pkg::t_phase dfm_phase = sfd_pkg::PH_HUNT_B;
    logic [15:0]     dfm_len   = '0;
    logic [15:0]     dfm_pid   = '0;
    logic [7:0]      dfm_src   = '0;
    int              dfm_count = 0;
    logic [15:0]     dfm_sum   = '0;
    logic [7:0]      dfm_ck_lo = '0;

    sfd_pkg::t_result frame_words_q[$];   // words the deframer owes us, oldest first
    int               errors      = 0;
    int               idle_cycles = 0;

    task automatic report_err(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_err($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Header fields always come from the frame in progress
    function automatic sfd_pkg::t_result mk_word(input sfd_pkg::t_kind k,
                                                 input logic [7:0] d,
                                                 input logic [11:0] idx);
        sfd_pkg::t_result w;
        w.kind       = k;
        w.data_byte  = d;
        w.byte_index = idx;
        w.frame_pid  = dfm_pid;
        w.body_len   = dfm_len;
        w.src_node   = dfm_src;
        w.frame_end  = (k != sfd_pkg::KIND_DATA);
        return w;
    endfunction

    // One received byte through the predicted deframer state machine
    task automatic deframe_byte(input logic [7:0] b);
        int lim;
        case (dfm_phase)
            sfd_pkg::PH_HUNT_R: begin
                if (b == sfd_pkg::SYNC_R) begin
                    dfm_sum   = 16'(sfd_pkg::SYNC_B) + 16'(sfd_pkg::SYNC_R);
                    dfm_phase = sfd_pkg::PH_LEN_LO;
                end else if (b != sfd_pkg::SYNC_B) begin
                    dfm_phase = sfd_pkg::PH_HUNT_B;
                end
                // a repeated 'B' keeps the hunt armed
            end
            sfd_pkg::PH_LEN_LO: begin
                dfm_len   = {8'h00, b};
                dfm_sum   = dfm_sum + b;
                dfm_phase = sfd_pkg::PH_LEN_HI;
            end
            sfd_pkg::PH_LEN_HI: begin
                dfm_len[15:8] = b;
                dfm_sum       = dfm_sum + b;
                dfm_phase     = sfd_pkg::PH_ID_LO;
            end
            sfd_pkg::PH_ID_LO: begin
                dfm_pid   = {8'h00, b};
                dfm_sum   = dfm_sum + b;
                dfm_phase = sfd_pkg::PH_ID_HI;
            end
            sfd_pkg::PH_ID_HI: begin
                dfm_pid[15:8] = b;
                dfm_sum       = dfm_sum + b;
                dfm_phase     = sfd_pkg::PH_SRC;
            end
            sfd_pkg::PH_SRC: begin
                dfm_src   = b;
                dfm_sum   = dfm_sum + b;
                dfm_phase = sfd_pkg::PH_DST;
            end
            sfd_pkg::PH_DST: begin
                dfm_sum = dfm_sum + b;
                lim = (int'(cfg_max_payload) < PAYLOAD_CEIL) ? int'(cfg_max_payload)
                                                              : PAYLOAD_CEIL;
                if (b != cfg_dest || int'(dfm_len) > lim) begin
                    // header rejected; hunt resumes on the next byte, no rescan
                    frame_words_q.push_back(mk_word(sfd_pkg::KIND_DROP, 8'h00, 12'h000));
                    dfm_phase = sfd_pkg::PH_HUNT_B;
                end else begin
                    dfm_count = 0;
                    dfm_phase = (dfm_len == 16'h0000) ? sfd_pkg::PH_CK_LO
                                                      : sfd_pkg::PH_PAYLOAD;
                end
            end
            sfd_pkg::PH_PAYLOAD: begin
                dfm_sum = dfm_sum + b;
                frame_words_q.push_back(mk_word(sfd_pkg::KIND_DATA, b, 12'(dfm_count)));
                dfm_count++;
                if (dfm_count >= int'(dfm_len))
                    dfm_phase = sfd_pkg::PH_CK_LO;
            end
            sfd_pkg::PH_CK_LO: begin
                dfm_ck_lo = b;
                dfm_phase = sfd_pkg::PH_CK_HI;
            end
            sfd_pkg::PH_CK_HI: begin
                if ({b, dfm_ck_lo} == dfm_sum)
                    frame_words_q.push_back(mk_word(sfd_pkg::KIND_GOOD, 8'h00, 12'h000));
                else
                    frame_words_q.push_back(mk_word(sfd_pkg::KIND_BAD_SUM, 8'h00, 12'h000));
                dfm_phase = sfd_pkg::PH_HUNT_B;
            end
            default: begin
                dfm_phase = (b == sfd_pkg::SYNC_B) ? sfd_pkg::PH_HUNT_R
                                                   : sfd_pkg::PH_HUNT_B;
            end
        endcase
    endtask

    // Byte driver: a new word goes out at the falling edge once the previous one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!byte_ch.valid || byte_taken)) begin
            byte_taken = 1'b0;
            if (rx_bytes_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.byte_in <= rx_bytes_q.pop_front();
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure
    always @(negedge i_clk) begin
        if (i_rst_n)
            res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: registers, accepted bytes and result words, all seen at the rising edge.
    // Also the watchdog, which counts edges where nothing moves on any channel.
    always @(posedge i_clk) begin
        sfd_pkg::t_result want;
        bit               moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                if (frame_words_q.size() == 0) begin
                    report_err($sformatf("unexpected word kind %0d data 0x%0h",
                                         res_ch.kind, res_ch.data_byte));
                end else begin
                    want = frame_words_q.pop_front();
                    check_field("kind", res_ch.kind, want.kind);
                    check_field("data_byte", res_ch.data_byte, want.data_byte);
                    check_field("byte_index", res_ch.byte_index, want.byte_index);
                    check_field("frame_pid", res_ch.frame_pid, want.frame_pid);
                    check_field("body_len", res_ch.body_len, want.body_len);
                    check_field("src_node", res_ch.src_node, want.src_node);
                    check_field("frame_end", res_ch.frame_end, want.frame_end);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                moved = 1'b1;
                case (cfg_ch.index)
                    sfd_pkg::REG_MAX_PAYLOAD:
                        cfg_max_payload = cfg_ch.data[sfd_pkg::MAXPL_W-1:0];
                    sfd_pkg::REG_EXP_DEST:
                        cfg_dest = cfg_ch.data[7:0];
                    default: ;
                endcase
            end
            if (byte_ch.valid && byte_ch.ready) begin
                moved      = 1'b1;
                byte_taken = 1'b1;
                deframe_byte(byte_ch.byte_in);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("Watchdog: no word moved for %0d cycles", WATCHDOG_MAX);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input bit in_frame);
        rx_bytes_q.push_back(b);
        if (in_frame)
            frame_bytes++;
    endtask

    // Header, n_body payload bytes, then the checksum if asked for.
    // A corrupted checksum is flipped by a nonzero mask, so it can never match.
    task automatic send_frame(input logic [15:0] len, input logic [15:0] pid,
                              input logic [7:0] src, input logic [7:0] dst,
                              input int n_body, input bit with_sum, input bit corrupt);
        logic [15:0] sum;
        logic [7:0]  hdr[8];
        logic [7:0]  b;
        hdr = '{sfd_pkg::SYNC_B, sfd_pkg::SYNC_R, len[7:0], len[15:8],
                pid[7:0], pid[15:8], src, dst};
        sum = '0;
        foreach (hdr[i]) begin
            push_byte(hdr[i], 1'b1);
            sum = sum + hdr[i];
        end
        for (int i = 0; i < n_body; i++) begin
            // sync bytes inside a payload must not resync the hunt
            case ($urandom_range(9))
                0:       b = sfd_pkg::SYNC_B;
                1:       b = sfd_pkg::SYNC_R;
                default: b = 8'($urandom);
            endcase
            push_byte(b, 1'b1);
            sum = sum + b;
        end
        if (with_sum) begin
            if (corrupt)
                sum = sum ^ 16'($urandom_range(1, 65535));
            push_byte(sum[7:0], 1'b1);
            push_byte(sum[15:8], 1'b1);
        end
    endtask

    task automatic cfg_write(input logic [sfd_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [sfd_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Destination write with junk in the upper data bits, which the register drops
    task automatic dest_write(input logic [7:0] d);
        logic [sfd_pkg::CFG_DATA_W-1:0] w;
        w      = sfd_pkg::CFG_DATA_W'($urandom);
        w[7:0] = d;
        cfg_write(sfd_pkg::REG_EXP_DEST, w);
    endtask

    // Mostly well-formed frames against the current registers, plus drops,
    // torn frames and line noise; runs until n_bytes of frame bytes are queued
    task automatic random_frames(input int n_bytes);
        int          stop_at;
        int          lim;
        int          short_lim;
        int          r;
        int          len;
        logic [7:0]  dst;
        stop_at   = frame_bytes + n_bytes;
        lim       = (int'(cfg_max_payload) < PAYLOAD_CEIL) ? int'(cfg_max_payload)
                                                            : PAYLOAD_CEIL;
        short_lim = (lim < 24) ? lim : 24;
        while (frame_bytes < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                len = $urandom_range(short_lim, 0);
                send_frame(16'(len), 16'($urandom), 8'($urandom), cfg_dest, len, 1'b1,
                           $urandom_range(99) < 15);
            end else if (r < 78) begin
                // length over the limit; all 16 length bits get exercised here
                len = $urandom_range(65535, lim + 1);
                send_frame(16'(len), 16'($urandom), 8'($urandom), cfg_dest, 0, 1'b0, 1'b0);
            end else if (r < 86) begin
                dst = cfg_dest ^ 8'($urandom_range(1, 255));
                len = $urandom_range(short_lim, 0);
                send_frame(16'(len), 16'($urandom), 8'($urandom), dst, 0, 1'b0, 1'b0);
            end else if (r < 92) begin
                // torn frame: following bytes get swallowed as payload until it closes
                len = $urandom_range(short_lim > 2 ? short_lim : 2, 2);
                send_frame(16'(len), 16'($urandom), 8'($urandom), cfg_dest,
                           $urandom_range(len - 1, 0), 1'b0, 1'b0);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    case ($urandom_range(3))
                        0:       push_byte(sfd_pkg::SYNC_B, 1'b0);
                        1:       push_byte(sfd_pkg::SYNC_R, 1'b0);
                        default: push_byte(8'($urandom), 1'b0);
                    endcase
                end
            end
        end
    endtask

    // Everything sent, taken and answered; then let the last no-result bytes settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_bytes_q.size() != 0 || byte_ch.valid || frame_words_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = sfd_pkg::REG_MAX_PAYLOAD;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: max_payload 1024, destination 0.
        // Hunt: 'B' then a non-sync byte drops back, a lone 'R' is ignored,
        // and 'B' 'B' 'R' still opens a header.
        push_byte(sfd_pkg::SYNC_B, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(sfd_pkg::SYNC_R, 1'b0);
        push_byte(sfd_pkg::SYNC_B, 1'b0);
        send_frame(16'd0, 16'hFFFF, 8'hFF, 8'h00, 0, 1'b1, 1'b0);   // empty payload
        send_frame(16'd3, 16'h0000, 8'h00, 8'h00, 3, 1'b1, 1'b0);
        send_frame(16'd2, 16'h1234, 8'h5A, 8'h00, 2, 1'b1, 1'b1);   // bad checksum
        send_frame(16'd1, 16'h00AA, 8'h01, 8'h01, 0, 1'b0, 1'b0);   // wrong destination
        send_frame(16'd1025, 16'h8001, 8'h80, 8'h00, 0, 1'b0, 1'b0); // just over the limit
        send_frame(16'd1, 16'h7FFE, 8'h7F, 8'h00, 1, 1'b1, 1'b0);   // right after a drop
        random_frames(130);
        wait_idle();

        // Widest register setting: the hard ceiling of 4096 governs
        cfg_write(sfd_pkg::REG_MAX_PAYLOAD, 13'h1FFF);
        dest_write(8'hFF);
        send_frame(16'd4097, 16'($urandom), 8'($urandom), 8'hFF, 0, 1'b0, 1'b0);
        send_frame(16'hFFFF, 16'($urandom), 8'($urandom), 8'hFF, 0, 1'b0, 1'b0);
        random_frames(120);
        wait_idle();

        // Zero max_payload: only empty frames get through
        cfg_write(sfd_pkg::REG_MAX_PAYLOAD, 13'h0000);
        dest_write(8'($urandom));
        send_frame(16'd1, 16'($urandom), 8'($urandom), cfg_dest, 0, 1'b0, 1'b0);
        send_frame(16'd0, 16'($urandom), 8'($urandom), cfg_dest, 0, 1'b1, 1'b0);
        random_frames(100);
        wait_idle();

        // Unmapped indexes, then a small random limit; the first run goes with no idling
        cfg_write(REG_SPARE_2, sfd_pkg::CFG_DATA_W'($urandom));
        cfg_write(REG_SPARE_3, sfd_pkg::CFG_DATA_W'($urandom));
        cfg_write(sfd_pkg::REG_MAX_PAYLOAD, sfd_pkg::CFG_DATA_W'($urandom_range(64, 1)));
        dest_write(8'($urandom));
        steady = 1'b1;
        random_frames(130);
        wait_idle();
        steady = 1'b0;
        random_frames(90);
        wait_idle();

        // Limit exactly at the ceiling
        cfg_write(sfd_pkg::REG_MAX_PAYLOAD, sfd_pkg::CFG_DATA_W'(PAYLOAD_CEIL));
        dest_write(8'h00);
        random_frames(70);
        wait_idle();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
